FILE: hw/rtl/sdsq_pkg.sv
// ----------------------------------------------------------------------------
// sdsq_pkg
// Types and constants shared by the sphere depth square-root core and its
// port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsq_pkg;

   // stream widths, fields packed from bit 0 and padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam int RADIUS_W = 6;
   localparam int OFFSET_W = 8;
   localparam int DEPTH_W  = 9;

   // radius saturation point
   localparam int MAX_RADIUS = 63;

   // newton iteration
   localparam int ROOT_W     = 9;
   localparam int ARG_W      = 16;
   localparam int ROOT_START = 128;
   localparam int ITER_LIMIT = 64;
   localparam int ITER_W     = 6;
   localparam int DEPTH_MAX  = 255;

   // squaring pass: radius, then offset x, then offset y
   localparam int SQ_STEPS = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage : sdsq_pkg

`default_nettype wire

FILE: hw/rtl/sphere_depth_sqrt_core.sv
// ----------------------------------------------------------------------------
// sphere_depth_sqrt_core
// Signed doubled sphere depth: +/- 2 * newton root of |r*r - dx*dx - dy*dy|,
// using one shared 8x8 multiplier and one restoring divider.
//
//   channel  dir  width  contents
//   req      in   24     radius, offset_x, offset_y
//   rsp      out  16     depth
//
// A word passes the accept state, three squaring steps on the multiplier,
// then per newton step (at most 64, under ten in practice) a 16-bit restoring
// division and an update, and a final state that hands the result to rsp.
// Reset is synchronous and active high; no word is in flight after it.
// A new word is taken while a finished result still waits on rsp; a stalled
// result only holds the core in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_depth_sqrt_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [5:0] radius, [13:6] offset_x, [21:14] offset_y, [23:22] zero
   input  wire logic [sdsq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [8:0] depth, [15:9] zero
   output logic [sdsq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import sdsq_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]          sq_cnt_ff, sq_cnt_in;
   logic [3:0]          bit_cnt_ff, bit_cnt_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [OFFSET_W-1:0] op_a_ff, op_a_in;
   logic [OFFSET_W-1:0] op_b_ff, op_b_in;
   logic [OFFSET_W-1:0] op_c_ff, op_c_in;
   logic signed [16:0]  acc_ff, acc_in;
   logic [ARG_W-1:0]    n_ff, n_in;
   logic                neg_ff, neg_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ROOT_W-1:0]   rem_ff, rem_in;
   logic [ARG_W-1:0]    quo_ff, quo_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;

   logic [RADIUS_W-1:0] radius;
   logic [OFFSET_W-1:0] offset_x;
   logic [OFFSET_W-1:0] offset_y;
   logic [RADIUS_W-1:0] radius_sat;
   logic [2*OFFSET_W-1:0] product;
   logic [ROOT_W:0]     trial;
   logic                trial_ge;
   logic [ARG_W:0]      root_sum;
   logic [ROOT_W-1:0]   root_next;
   logic [ROOT_W-1:0]   root_diff;
   logic [ROOT_W:0]     mag;
   logic [DEPTH_W-1:0]  mag_sat;

   assign radius   = req_tdata[RADIUS_W-1:0];
   assign offset_x = req_tdata[RADIUS_W+OFFSET_W-1:RADIUS_W];
   assign offset_y = req_tdata[RADIUS_W+2*OFFSET_W-1:RADIUS_W+OFFSET_W];

   assign radius_sat = ({1'b0, radius} > 7'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;

   // shared multiplier
   assign product = op_a_ff * op_a_ff;

   // shared divider, one quotient bit a cycle
   assign trial    = {rem_ff, quo_ff[ARG_W-1]};
   assign trial_ge = trial >= {1'b0, root_ff};

   assign root_sum  = {{(ARG_W-ROOT_W+1){1'b0}}, root_ff} + {1'b0, quo_ff};
   assign root_next = ROOT_W'(root_sum >> 1);
   assign root_diff = (root_ff > root_next) ? root_ff - root_next : root_next - root_ff;

   assign mag     = {root_ff, 1'b0};
   assign mag_sat = (mag > (ROOT_W+1)'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX) : mag[DEPTH_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-DEPTH_W){1'b0}}, depth_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_cnt_ff  <= sq_cnt_in;
      bit_cnt_ff <= bit_cnt_in;
      iter_ff    <= iter_in;
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      op_c_ff    <= op_c_in;
      acc_ff     <= acc_in;
      n_ff       <= n_in;
      neg_ff     <= neg_in;
      root_ff    <= root_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      depth_ff   <= depth_in;
   end

   always_comb begin
      state_in     = state_ff;
      sq_cnt_in    = sq_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      iter_in      = iter_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      op_c_in      = op_c_ff;
      acc_in       = acc_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_a_in   = {{(OFFSET_W-RADIUS_W){1'b0}}, radius_sat};
               op_b_in   = offset_x[OFFSET_W-1] ? OFFSET_W'(-offset_x) : offset_x;
               op_c_in   = offset_y[OFFSET_W-1] ? OFFSET_W'(-offset_y) : offset_y;
               sq_cnt_in = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // first square adds, the offsets subtract
            if (sq_cnt_ff == '0) begin
               acc_in = signed'({1'b0, product});
            end else begin
               acc_in = acc_ff - signed'({1'b0, product});
            end
            op_a_in   = op_b_ff;
            op_b_in   = op_c_ff;
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'(SQ_STEPS-1)) begin
               state_in = ST_DIVIDE;
            end
            if (state_in == ST_DIVIDE) begin
               neg_in     = acc_in[16];
               n_in       = acc_in[16] ? ARG_W'(-acc_in) : acc_in[ARG_W-1:0];
               quo_in     = n_in;
               rem_in     = '0;
               root_in    = ROOT_W'(ROOT_START);
               bit_cnt_in = '0;
               iter_in    = '0;
            end
         end
         ST_DIVIDE: begin
            rem_in     = trial_ge ? ROOT_W'(trial - {1'b0, root_ff}) : trial[ROOT_W-1:0];
            quo_in     = {quo_ff[ARG_W-2:0], trial_ge};
            bit_cnt_in = bit_cnt_ff + 4'd1;
            if (bit_cnt_ff == 4'(ARG_W-1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            root_in = root_next;
            // a zero root would end the iteration as it stands
            if (root_diff <= ROOT_W'(1) || iter_ff == ITER_W'(ITER_LIMIT-1)
                  || root_next == '0) begin
               state_in = ST_DONE;
            end else begin
               iter_in    = iter_ff + ITER_W'(1);
               quo_in     = n_ff;
               rem_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               depth_in     = neg_ff ? DEPTH_W'(-mag_sat) : mag_sat;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : sphere_depth_sqrt_core

`default_nettype wire

FILE: hw/rtl/sdsq_checker.sv
// ----------------------------------------------------------------------------
// sdsq_checker
// Port-level checks on the sphere depth core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsq_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [sdsq_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sdsq_pkg::*;

   // the core works on one word at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted word");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // depth is never zero and the padding stays clear
   a_rsp_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DEPTH_W-1:0] != '0
                     && rsp_tdata[RSP_DATA_W-1:DEPTH_W] == '0)
      else $error("malformed depth word");

   // nothing left over from before reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("core not idle after reset");

endmodule : sdsq_checker

bind sphere_depth_sqrt_core sdsq_checker u_sdsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
